// ===== rtl/plu_pkg.sv =====
// Package for the piecewise linear lookup unit: widths, table size, state type,
// the status codes and the arctangent table in degrees. No dependencies.
`default_nettype none
package plu_pkg;
    localparam int MaxPoints  = 256;
    localparam int IdxW       = 8;
    localparam int CntW       = 9;
    localparam int FracBits   = 16;
    localparam int TableFrac  = 24;
    localparam int AngleSteps = 24;
    localparam int StepW      = 5;

    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusZeroW = 2'd1;
    localparam logic [1:0] StatusRange = 2'd2;

    localparam logic ActLoad  = 1'b0;
    localparam logic ActQuery = 1'b1;

    typedef struct packed {
        logic               action;
        logic [IdxW-1:0]    entry_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
    } t_req;

    typedef struct packed {
        logic signed [31:0] height;
        logic signed [23:0] angle_deg;
        logic               inside_res;
        logic signed [31:0] clamp_x;
        logic signed [31:0] clamp_y;
        logic [1:0]         status;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_END, S_WAIT_END, S_SEARCH, S_SEARCH_W, S_RD_L, S_RD_R,
        S_PREP, S_NORM, S_MATH, S_FINISH, S_OUT
    } t_state;

    function automatic logic signed [31:0] atan_deg(input logic [StepW-1:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:  v = 32'sd754974720;
            5'd1:  v = 32'sd445687602;
            5'd2:  v = 32'sd235489088;
            5'd3:  v = 32'sd119537938;
            5'd4:  v = 32'sd60000934;
            5'd5:  v = 32'sd30029717;
            5'd6:  v = 32'sd15018523;
            5'd7:  v = 32'sd7509720;
            5'd8:  v = 32'sd3754917;
            5'd9:  v = 32'sd1877466;
            5'd10: v = 32'sd938734;
            5'd11: v = 32'sd469367;
            5'd12: v = 32'sd234684;
            5'd13: v = 32'sd117342;
            5'd14: v = 32'sd58671;
            5'd15: v = 32'sd29335;
            5'd16: v = 32'sd14668;
            5'd17: v = 32'sd7334;
            5'd18: v = 32'sd3667;
            5'd19: v = 32'sd1833;
            5'd20: v = 32'sd917;
            5'd21: v = 32'sd458;
            5'd22: v = 32'sd229;
            5'd23: v = 32'sd115;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/plu_if.sv =====
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; the payload type is chosen at instantiation.
`default_nettype none
interface plu_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/plu_table.sv =====
// Breakpoint memory: one synchronous RAM of (x, y) pairs, one port.
// Depends on plu_pkg.
`default_nettype none
module plu_table (
    input  wire                    i_clk,
    input  wire                    i_we,
    input  wire  [plu_pkg::IdxW-1:0] i_addr,
    input  wire  [63:0]            i_wdata,
    output logic [63:0]            o_rdata
);
    import plu_pkg::*;
    logic [63:0] r_mem [MaxPoints];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/plu_divider.sv =====
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit
// divisor (33-bit magnitude). Depends on nothing but the clock and reset.
`default_nettype none
module plu_divider (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [63:0] i_num,
    input  wire  [32:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_quo, n_quo;
    logic [33:0] r_rem, n_rem;
    logic [32:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [33:0] w_sh;

    always_comb begin
        w_sh   = {r_rem[32:0], r_quo[63]};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        o_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_num;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
            end
        end else begin
            o_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        if (i_start) begin
            r_den <= i_den;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end
    assign o_quo = r_quo;
endmodule
`default_nettype wire

// ===== rtl/plu_cordic.sv =====
// Vectoring CORDIC for the segment slope angle, one step per cycle, result in
// degrees with FracBits fraction bits. Depends on plu_pkg.
`default_nettype none
module plu_cordic (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire  signed [33:0] i_dw,
    input  wire  signed [33:0] i_dy,
    output logic               o_done,
    output logic signed [23:0] o_angle
);
    import plu_pkg::*;
    logic signed [44:0] r_xv, n_xv, r_yv, n_yv;
    logic signed [31:0] r_z, n_z;
    logic [StepW-1:0]   r_i, n_i;
    logic               r_norm, n_norm, r_busy, n_busy, r_zero, n_zero;
    logic [44:0]        w_mx, w_my;
    logic signed [44:0] w_xs, w_ys;
    logic [31:0]        w_r;
    logic [23:0]        w_rs;

    always_comb begin
        n_xv = r_xv; n_yv = r_yv; n_z = r_z; n_i = r_i;
        n_norm = r_norm; n_busy = r_busy; n_zero = r_zero;
        w_mx = r_xv[44] ? 45'(-r_xv) : 45'(r_xv);
        w_my = r_yv[44] ? 45'(-r_yv) : 45'(r_yv);
        w_xs = r_xv >>> r_i;
        w_ys = r_yv >>> r_i;
        if (i_start) begin
            // Mirror to the right half-plane first.
            n_xv = i_dw[33] ? -45'(i_dw) : 45'(i_dw);
            n_yv = i_dw[33] ? -45'(i_dy) : 45'(i_dy);
            n_z = '0; n_i = '0; n_norm = 1'b1; n_busy = 1'b1;
            n_zero = (i_dy == 34'sd0);
        end else if (r_busy && r_norm) begin
            if ((w_mx | w_my) < (45'd1 << 40)) begin
                n_xv = r_xv <<< 1; n_yv = r_yv <<< 1;
            end else begin
                n_norm = 1'b0;
            end
        end else if (r_busy) begin
            if (r_yv > 0) begin
                n_xv = r_xv + w_ys; n_yv = r_yv - w_xs; n_z = r_z + atan_deg(r_i);
            end else if (r_yv < 0) begin
                n_xv = r_xv - w_ys; n_yv = r_yv + w_xs; n_z = r_z - atan_deg(r_i);
            end
            n_i = r_i + 1'b1;
            if (r_i == StepW'(AngleSteps - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_comb begin
        w_r = r_z[31] ? 32'(-r_z) : 32'(r_z);
        w_r = (w_r + (32'd1 << (TableFrac - FracBits - 1))) >> (TableFrac - FracBits);
        if (w_r > (32'd90 << FracBits)) begin
            w_r = 32'd90 << FracBits;
        end
        w_rs = w_r[23:0];
        o_angle = r_zero ? 24'sd0 : (r_z[31] ? -$signed(w_rs) : $signed(w_rs));
        o_done  = !r_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_xv <= n_xv; r_yv <= n_yv; r_z <= n_z; r_i <= n_i;
        r_norm <= n_norm; r_zero <= n_zero;
    end
endmodule
`default_nettype wire

// ===== rtl/piecewise_linear_lookup_unit.sv =====
// Top level of the piecewise linear lookup unit: sequencer, breakpoint RAM,
// divider and CORDIC. Depends on plu_pkg, plu_if and the three submodules.
//
// Requests arrive on i_req (valid/ready); each yields one result on o_res.
// A load request writes breakpoint entry_index into the RAM, or returns
// status 2 without writing when the index is at or beyond the point count;
// its result is valid in the cycle after it is accepted. A query request reads
// the first and last breakpoints, binary-searches the table one RAM read per
// halving, up to eight halvings for 256 points, reads the segment ends, then,
// for a segment of nonzero width, runs the restoring divider and the CORDIC (up
// to 40 normalizing shifts, a check step and 24 steps) in parallel. The query
// time is set by the one step per cycle of the divider and the CORDIC and by
// the single RAM port. One request is in the block at a time; i_req.ready is
// high only when idle. The result waits in an output register while
// o_res.ready is low, and the block takes no new request until it is taken.
// Reset sets point_count to 2 and clears control state; breakpoint entries
// hold garbage until written. i_cfg_we writes point_count; the user raises it
// only while the block is idle, and the block itself does not enforce this.
`default_nettype none
module piecewise_linear_lookup_unit (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire  [plu_pkg::CntW-1:0] i_cfg_wdata,
    plu_if.sink                      i_req,
    plu_if.source                    o_res
);
    import plu_pkg::*;

    t_state r_state, n_state;
    logic [CntW-1:0] r_count;
    t_req  r_req;
    t_res  r_res, n_res;
    logic [IdxW-1:0] r_lo, n_lo, r_hi, n_hi, w_last, w_mid, w_addr;
    logic signed [31:0] r_x0, r_y0, r_x1, r_y1, r_fx, r_fy, r_lx, r_ly;
    logic signed [31:0] n_x0, n_y0, n_x1, n_y1, n_fx, n_fy, n_lx, n_ly;
    logic [CntW-1:0] w_n;
    logic        w_we, w_div_start, w_cor_start, w_div_done, w_cor_done;
    logic [63:0] w_rdata, w_quo;
    logic signed [31:0] w_rx, w_ry;
    logic signed [33:0] w_dw, w_dx, w_dy;
    logic [32:0] w_mw, w_mdx, w_mdy;
    logic [63:0] w_prod;
    logic [63:0] w_num;
    logic [32:0] r_mw, n_mw;
    logic        r_neg, n_neg;
    logic [63:0] w_q;
    logic signed [65:0] w_h;
    logic signed [23:0] w_angle;

    always_comb begin
        w_n = r_count;
        if (r_count < CntW'(2)) w_n = CntW'(2);
        if (r_count > CntW'(MaxPoints)) w_n = CntW'(MaxPoints);
    end
    assign w_last = IdxW'(w_n - CntW'(1));
    assign w_mid  = IdxW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign w_rx   = $signed(w_rdata[63:32]);
    assign w_ry   = $signed(w_rdata[31:0]);

    plu_table u_table (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata({i_req.payload.coord_x, i_req.payload.coord_y}), .o_rdata(w_rdata)
    );
    plu_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_num), .i_den(w_mw), .o_done(w_div_done), .o_quo(w_quo)
    );
    plu_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_cor_start),
        .i_dw(34'(r_x1) - 34'(r_x0)), .i_dy(34'(r_y1) - 34'(r_y0)),
        .o_done(w_cor_done), .o_angle(w_angle)
    );

    // Differences and product for the divider setup, and the height from its quotient.
    always_comb begin
        w_dw  = 34'(r_x1) - 34'(r_x0);
        w_dx  = 34'(r_req.coord_x) - 34'(r_x0);
        w_dy  = 34'(r_y1) - 34'(r_y0);
        w_mw  = w_dw[33] ? 33'(-w_dw) : 33'(w_dw);
        w_mdx = w_dx[33] ? 33'(-w_dx) : 33'(w_dx);
        w_mdy = w_dy[33] ? 33'(-w_dy) : 33'(w_dy);
        w_prod = 64'(w_mdy) * 64'(w_mdx);
        // Both magnitudes stay below 2^32, so the rounded dividend fits 64 bits.
        w_num = w_prod + 64'(w_mw >> 1);
        w_q = (w_quo > (64'd1 << 40)) ? (64'd1 << 40) : w_quo;
        w_h = 66'(r_y0) + (r_neg ? -$signed(66'(w_q)) : $signed(66'(w_q)));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.payload.action == ActLoad) ? S_OUT : S_RD_END;
                end
            end
            S_RD_END:   n_state = S_WAIT_END;
            S_WAIT_END: n_state = S_SEARCH;
            S_SEARCH: begin
                if (r_hi - r_lo <= IdxW'(1)) n_state = S_RD_L;
                else n_state = S_SEARCH_W;
            end
            S_SEARCH_W: n_state = S_SEARCH;
            S_RD_L:     n_state = S_RD_R;
            S_RD_R:     n_state = S_PREP;
            S_PREP:     n_state = S_NORM;
            S_NORM:     n_state = S_MATH;
            S_MATH:     if (w_div_done && w_cor_done) n_state = S_FINISH;
            S_FINISH:   n_state = S_OUT;
            S_OUT:      if (o_res.ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_lo = r_lo; n_hi = r_hi; n_x0 = r_x0; n_y0 = r_y0; n_x1 = r_x1; n_y1 = r_y1;
        n_fx = r_fx; n_fy = r_fy; n_lx = r_lx; n_ly = r_ly;
        n_mw = r_mw; n_neg = r_neg; n_res = r_res;
        w_we = 1'b0; w_addr = r_lo; w_div_start = 1'b0; w_cor_start = 1'b0;
        i_req.ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                w_addr = i_req.payload.entry_index;
                n_res = '0;
                if (i_req.valid && i_req.payload.action == ActLoad) begin
                    if (CntW'(i_req.payload.entry_index) >= w_n) begin
                        n_res.status = StatusRange;
                    end else begin
                        w_we = 1'b1;
                    end
                end
                w_addr = (i_req.valid && i_req.payload.action == ActQuery)
                    ? IdxW'(0) : i_req.payload.entry_index;
            end
            S_RD_END: begin
                w_addr = w_last;
                n_fx = w_rx; n_fy = w_ry;
            end
            S_WAIT_END: begin
                n_lx = w_rx; n_ly = w_ry;
                if (r_req.coord_x <= r_fx) begin
                    n_lo = '0; n_hi = IdxW'(1);
                end else if (r_req.coord_x > w_rx) begin
                    n_lo = w_last - IdxW'(1); n_hi = w_last;
                end else begin
                    n_lo = '0; n_hi = w_last;
                end
                w_addr = IdxW'(({1'b0, n_lo} + {1'b0, n_hi}) >> 1);
            end
            S_SEARCH: begin
                w_addr = w_mid;
            end
            S_SEARCH_W: begin
                if (r_req.coord_x <= w_rx) n_hi = w_mid; else n_lo = w_mid;
                w_addr = IdxW'(({1'b0, n_lo} + {1'b0, n_hi}) >> 1);
            end
            S_RD_L: begin
                w_addr = r_lo;
            end
            S_RD_R: begin
                w_addr = r_hi;
                n_x0 = w_rx; n_y0 = w_ry;
            end
            S_PREP: begin
                n_x1 = w_rx; n_y1 = w_ry;
            end
            S_NORM: begin
                n_mw  = w_mw;
                n_neg = ((w_dy[33] != w_dx[33]) != w_dw[33]) && w_dy != 0 && w_dx != 0;
                w_div_start = (w_mw != 0);
                w_cor_start = (w_mw != 0);
            end
            S_MATH: begin
            end
            S_FINISH: begin
                if (r_mw == 0) begin
                    n_res.status = StatusZeroW;
                    n_res.height = r_y0;
                    n_res.angle_deg = '0;
                end else begin
                    n_res.status = StatusOk;
                    n_res.angle_deg = w_angle;
                    if (w_h > 66'sd2147483647) n_res.height = 32'h7fffffff;
                    else if (w_h < -66'sd2147483648) n_res.height = 32'h80000000;
                    else n_res.height = w_h[31:0];
                end
                if (r_req.coord_x >= r_fx && r_req.coord_x <= r_lx) begin
                    n_res.inside_res = 1'b1;
                    n_res.clamp_x = r_req.coord_x; n_res.clamp_y = r_req.coord_y;
                end else if (r_req.coord_x < r_fx) begin
                    n_res.inside_res = 1'b0;
                    n_res.clamp_x = r_fx; n_res.clamp_y = r_fy;
                end else begin
                    n_res.inside_res = 1'b0;
                    n_res.clamp_x = r_lx; n_res.clamp_y = r_ly;
                end
            end
            default: begin
            end
        endcase
        o_res.valid   = (r_state == S_OUT);
        o_res.payload = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CntW'(2);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_count <= i_cfg_wdata;
        end
        if (r_state == S_IDLE && i_req.valid) r_req <= i_req.payload;
        r_lo <= n_lo; r_hi <= n_hi;
        r_x0 <= n_x0; r_y0 <= n_y0; r_x1 <= n_x1; r_y1 <= n_y1;
        r_fx <= n_fx; r_fy <= n_fy; r_lx <= n_lx; r_ly <= n_ly;
        r_mw <= n_mw; r_neg <= n_neg; r_res <= n_res;
    end
endmodule
`default_nettype wire

// ===== tb/sv/plu_lookup_scoreboard.sv =====
// Scoreboard for the piecewise linear lookup unit: a predictor of the breakpoint
// table and of each result, plus the queue of expected results. Depends on plu_pkg.
class plu_lookup_scoreboard;
    longint         table_x [plu_pkg::MaxPoints];
    longint         table_y [plu_pkg::MaxPoints];
    int unsigned    point_count;
    plu_pkg::t_res  expected_q [$];
    int             errors;

    function new();
        point_count = 2;
        errors      = 0;
        foreach (table_x[i]) begin
            table_x[i] = 0;
            table_y[i] = 0;
        end
    endfunction

    function void set_point_count(int unsigned v);
        point_count = v & 9'h1FF;
    endfunction

    function int unsigned points_used();
        if (point_count < 2) return 2;
        if (point_count > plu_pkg::MaxPoints) return plu_pkg::MaxPoints;
        return point_count;
    endfunction

    static function logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // CORDIC vectoring in degrees on operands normalized to [2^40, 2^41).
    static function longint slope_degrees(longint dw, longint dy);
        longint      xv, yv, zv, xs, ys, res;
        logic [63:0] m, r;
        if (dy == 0) return 0;
        if (dw < 0) begin
            dw = -dw;
            dy = -dy;
        end
        m  = (magnitude(dw) > magnitude(dy)) ? magnitude(dw) : magnitude(dy);
        xv = dw;
        yv = dy;
        zv = 0;
        while (m < (64'd1 << 40)) begin
            m  = m << 1;
            xv = xv * 2;
            yv = yv * 2;
        end
        for (int i = 0; i < plu_pkg::AngleSteps; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv > 0) begin
                xv = xv + ys;
                yv = yv - xs;
                zv = zv + longint'(plu_pkg::atan_deg(i[4:0]));
            end else if (yv < 0) begin
                xv = xv - ys;
                yv = yv + xs;
                zv = zv - longint'(plu_pkg::atan_deg(i[4:0]));
            end
        end
        r = magnitude(zv);
        r = (r + (64'd1 << (plu_pkg::TableFrac - plu_pkg::FracBits - 1)))
            >> (plu_pkg::TableFrac - plu_pkg::FracBits);
        if (r > (64'd90 << plu_pkg::FracBits)) r = 64'd90 << plu_pkg::FracBits;
        res = longint'(r);
        return (zv < 0) ? -res : res;
    endfunction

    function plu_pkg::t_res predict(plu_pkg::t_req rq);
        plu_pkg::t_res res;
        int unsigned   n, lo, hi, mid;
        longint        x, y, x0, y0, x1, y1, dw, dx, dy, h, ang, cx, cy;
        logic [63:0]   mw, q;
        logic          neg;
        n   = points_used();
        x   = longint'(rq.coord_x);
        y   = longint'(rq.coord_y);
        res = '0;
        res.status = plu_pkg::StatusOk;
        if (rq.action == plu_pkg::ActLoad) begin
            if (rq.entry_index >= n) begin
                res.status = plu_pkg::StatusRange;
            end else begin
                table_x[rq.entry_index] = x;
                table_y[rq.entry_index] = y;
            end
            return res;
        end
        lo = 0;
        hi = n - 1;
        if (x <= table_x[0]) begin
            lo = 0;
        end else if (x > table_x[n-1]) begin
            lo = n - 2;
        end else begin
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (x <= table_x[mid]) hi = mid;
                else lo = mid;
            end
        end
        x0 = table_x[lo];
        y0 = table_y[lo];
        x1 = table_x[lo+1];
        y1 = table_y[lo+1];
        dw = x1 - x0;
        dx = x - x0;
        dy = y1 - y0;
        if (dw == 0) begin
            res.status = plu_pkg::StatusZeroW;
            h   = y0;
            ang = 0;
        end else begin
            mw  = magnitude(dw);
            q   = (magnitude(dy) * magnitude(dx) + mw / 2) / mw;
            neg = ((dy < 0) != (dx < 0)) != (dw < 0);
            if (q > (64'd1 << 40)) q = 64'd1 << 40;
            if (dy == 0 || dx == 0) neg = 1'b0;
            h = y0 + (neg ? -longint'(q) : longint'(q));
            if (h > 64'sd2147483647) h = 64'sd2147483647;
            if (h < -64'sd2147483648) h = -64'sd2147483648;
            ang = slope_degrees(dw, dy);
        end
        if (x >= table_x[0] && x <= table_x[n-1]) begin
            res.inside_res = 1'b1;
            cx = x;
            cy = y;
        end else if (x < table_x[0]) begin
            cx = table_x[0];
            cy = table_y[0];
        end else begin
            cx = table_x[n-1];
            cy = table_y[n-1];
        end
        res.height    = h[31:0];
        res.angle_deg = ang[23:0];
        res.clamp_x   = cx[31:0];
        res.clamp_y   = cy[31:0];
        return res;
    endfunction

    function void note_request(plu_pkg::t_req rq);
        expected_q.push_back(predict(rq));
    endfunction

    function void check_result(plu_pkg::t_res got);
        plu_pkg::t_res exp_r;
        if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected: %p", $realtime, got);
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        if (got.height !== exp_r.height) begin
            $display("%0t: height expected %0d actual %0d",
                     $realtime, exp_r.height, got.height);
            errors++;
        end
        if (got.angle_deg !== exp_r.angle_deg) begin
            $display("%0t: angle_deg expected %0d actual %0d",
                     $realtime, exp_r.angle_deg, got.angle_deg);
            errors++;
        end
        if (got.inside_res !== exp_r.inside_res) begin
            $display("%0t: inside_res expected %0d actual %0d",
                     $realtime, exp_r.inside_res, got.inside_res);
            errors++;
        end
        if (got.clamp_x !== exp_r.clamp_x) begin
            $display("%0t: clamp_x expected %0d actual %0d",
                     $realtime, exp_r.clamp_x, got.clamp_x);
            errors++;
        end
        if (got.clamp_y !== exp_r.clamp_y) begin
            $display("%0t: clamp_y expected %0d actual %0d",
                     $realtime, exp_r.clamp_y, got.clamp_y);
            errors++;
        end
        if (got.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $realtime, exp_r.status, got.status);
            errors++;
        end
    endfunction
endclass

// ===== tb/sv/piecewise_linear_lookup_unit_test.sv =====
// Testbench top for the piecewise linear lookup unit: loads breakpoint tables
// at several point counts and checks queries against the scoreboard.
// Depends on plu_pkg, plu_if, plu_lookup_scoreboard and the unit itself.
module piecewise_linear_lookup_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import plu_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CntW-1:0]  cfg_wdata = '0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               quiet_cycles = 0;
    longint           tab_x [MaxPoints];
    longint           tab_y [MaxPoints];
    plu_lookup_scoreboard lookup_sb = new();

    plu_if #(.T(t_req)) req_if ();
    plu_if #(.T(t_res)) res_if ();

    piecewise_linear_lookup_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        res_if.ready   = 1'b0;
    end

    // Result side: check on acceptance, then pick the next ready at random.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) lookup_sb.check_result(res_if.payload);
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("piecewise_linear_lookup_unit_test: FAIL");
            $finish;
        end
    end

    task automatic send_request(logic act, logic [7:0] idx, longint x, longint y);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid               <= 1'b1;
        req_if.payload.action      <= act;
        req_if.payload.entry_index <= idx;
        req_if.payload.coord_x     <= x[31:0];
        req_if.payload.coord_y     <= y[31:0];
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        lookup_sb.note_request(req_if.payload);
    endtask

    task automatic drain_results();
        if (req_if.valid) req_if.valid <= 1'b0;
        while (lookup_sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_point_count(int unsigned v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v[CntW-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        lookup_sb.set_point_count(v);
    endtask

    // Fills every slot in use with ascending x, some runs of equal x.
    task automatic load_table(int unsigned n);
        longint step, slack, x;
        int     order [$];
        step  = $urandom_range(32'hFFFF_FFFF / n, 1);
        step  = step >> $urandom_range(28, 0);
        if (step < 1) step = 1;
        slack = 64'hFFFF_FFFF - (n - 1) * step;
        x     = -64'sd2147483648 + ($urandom % (slack + 1));
        for (int i = 0; i < n; i++) begin
            if (i > 0) x += ($urandom_range(7) == 0) ? 0 : $urandom_range(step, 0);
            tab_x[i] = x;
            tab_y[i] = longint'(signed'($urandom));
            order.push_back(i);
        end
        order.shuffle();
        foreach (order[k]) begin
            send_request(ActLoad, order[k][7:0], tab_x[order[k]], tab_y[order[k]]);
            // Occasionally a load beyond the point count, which must not write.
            if (n < MaxPoints && $urandom_range(15) == 0)
                send_request(ActLoad, 8'($urandom_range(255, n)), $urandom, $urandom);
        end
    endtask

    task automatic query_table(int unsigned n, int count);
        longint x, a, b;
        int     i;
        repeat (count) begin
            i = $urandom_range(n - 2);
            case ($urandom_range(5))
                0: x = tab_x[$urandom_range(n - 1)];
                1, 2: begin
                    a = tab_x[i];
                    b = tab_x[i+1];
                    x = a + (($urandom | (longint'($urandom) << 32)) & 64'h7FFF_FFFF_FFFF_FFFF)
                        % (b - a + 1);
                end
                3: x = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
                default: x = longint'(signed'($urandom));
            endcase
            send_request(ActQuery, 8'($urandom), x, longint'(signed'($urandom)));
        end
    endtask

    int unsigned counts [] = '{3, 7, 0, 33, 511, 1, 17, 64, 5, 100, 2, 300, 9};

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: two-point table at the field extremes.
        send_request(ActLoad, 0, -64'sd2147483648, -64'sd2147483648);
        send_request(ActLoad, 1, 64'sd2147483647, 64'sd2147483647);
        send_request(ActLoad, 2, 5, 5);
        send_request(ActLoad, 255, -1, -1);
        send_request(ActQuery, 8'hFF, -64'sd2147483648, 64'sd2147483647);
        send_request(ActQuery, 0, 64'sd2147483647, -64'sd2147483648);
        send_request(ActQuery, 0, 0, 0);
        send_request(ActQuery, 0, -1, -1);
        // Steep segment: extrapolation saturates high and low.
        send_request(ActLoad, 0, 0, 0);
        send_request(ActLoad, 1, 1, 64'sd2147483647);
        send_request(ActQuery, 0, 64'sd2147483647, 0);
        send_request(ActQuery, 0, -64'sd2147483648, 0);
        send_request(ActQuery, 0, 1, 3);
        // Falling segment and a flat segment.
        send_request(ActLoad, 1, 65536, -64'sd2147483648);
        send_request(ActQuery, 0, 32768, 7);
        send_request(ActLoad, 1, 65536, 0);
        send_request(ActQuery, 0, 40000, 7);
        // Zero-width segment, queried below, on and above it.
        send_request(ActLoad, 1, 0, 123456);
        send_request(ActQuery, 0, -5, 1);
        send_request(ActQuery, 0, 0, 2);
        send_request(ActQuery, 0, 9, 3);

        // Sender holds off until everything is back before the random part.
        drain_results();

        foreach (counts[p]) begin
            write_point_count(counts[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            load_table(lookup_sb.points_used());
            query_table(lookup_sb.points_used(), 35);
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (lookup_sb.errors == 0)
            $display("piecewise_linear_lookup_unit_test: PASS");
        else
            $display("piecewise_linear_lookup_unit_test: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/plu_pkg.sv
rtl/plu_if.sv
rtl/plu_table.sv
rtl/plu_divider.sv
rtl/plu_cordic.sv
rtl/piecewise_linear_lookup_unit.sv
tb/sv/plu_lookup_scoreboard.sv
tb/sv/piecewise_linear_lookup_unit_test.sv
